@@ sv/ctae_pkg.sv @@
// shared types, command codes and sgr constants for the cursor and attribute engine
`timescale 1ns / 1ps
`default_nettype none
package ctae_pkg;

    // command codes
    localparam logic [3:0] MODE_CR        = 4'd0;
    localparam logic [3:0] MODE_DOWN      = 4'd1;
    localparam logic [3:0] MODE_UP        = 4'd2;
    localparam logic [3:0] MODE_RIGHT     = 4'd3;
    localparam logic [3:0] MODE_LEFT      = 4'd4;
    localparam logic [3:0] MODE_MOVE      = 4'd5;
    localparam logic [3:0] MODE_TAB       = 4'd6;
    localparam logic [3:0] MODE_BACKSPACE = 4'd7;
    localparam logic [3:0] MODE_SGR       = 4'd8;

    // configuration register indexes
    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    // register reset values and the largest screen size
    localparam logic [8:0] WIDTH_RESET  = 9'd80;
    localparam logic [8:0] HEIGHT_RESET = 9'd24;
    localparam logic [8:0] DIM_MAX      = 9'd256;

    // horizontal tab spacing
    localparam int TAB_STOP = 8;

    // sgr parameter codes
    localparam logic [11:0] SGR_RESET      = 12'd0;
    localparam logic [11:0] SGR_BRIGHT     = 12'd1;
    localparam logic [11:0] SGR_DIM        = 12'd2;
    localparam logic [11:0] SGR_UNDERSCORE = 12'd4;
    localparam logic [11:0] SGR_BLINK      = 12'd5;
    localparam logic [11:0] SGR_REVERSE    = 12'd7;
    localparam logic [11:0] SGR_HIDDEN     = 12'd8;
    localparam logic [11:0] SGR_FG_FIRST   = 12'd30;
    localparam logic [11:0] SGR_FG_LAST    = 12'd39;
    localparam logic [11:0] SGR_BG_FIRST   = 12'd40;
    localparam logic [11:0] SGR_BG_LAST    = 12'd49;

    // attribute bit positions
    localparam int ATTR_BRIGHT     = 0;
    localparam int ATTR_DIM        = 1;
    localparam int ATTR_UNDERSCORE = 2;
    localparam int ATTR_BLINK      = 3;
    localparam int ATTR_REVERSE    = 4;
    localparam int ATTR_HIDDEN     = 5;

    // default colours
    localparam logic [2:0] FG_DEFAULT = 3'd7;
    localparam logic [2:0] BG_DEFAULT = 3'd0;

    // one decoded command
    typedef struct packed {
        logic [3:0]  mode;
        logic [11:0] first_value;
        logic        first_present;
        logic [11:0] second_value;
        logic        second_present;
        logic        sgr_start;
    } cmd_t;

    // cursor and rendition state
    typedef struct packed {
        logic [7:0] col;
        logic [7:0] row;
        logic [5:0] attr;
        logic [2:0] fg;
        logic [2:0] bg;
    } term_state_t;

    // per-request status
    typedef struct packed {
        logic [11:0] scroll;
        logic        rejected;
    } status_t;

endpackage : ctae_pkg
`default_nettype wire

@@ sv/ctae_exec.sv @@
// command execution logic: next cursor, rendition state and status for one request
`timescale 1ns / 1ps
`default_nettype none
module ctae_exec (
    input  wire ctae_pkg::cmd_t      cmd,
    input  wire ctae_pkg::term_state_t cur,
    input  wire logic [8:0]          width_cfg,
    input  wire logic [8:0]          height_cfg,
    output ctae_pkg::term_state_t    nxt,
    output ctae_pkg::status_t        status
);
    import ctae_pkg::*;

    localparam logic [9:0] TAB_W = 10'(TAB_STOP);

    logic [8:0]  w;
    logic [8:0]  h;
    logic [8:0]  w_m1;
    logic [11:0] n_down;
    logic [8:0]  avail;
    logic [8:0]  moved;
    logic [11:0] count;
    logic [12:0] right_sum;
    logic [11:0] r1;
    logic [11:0] c1;
    logic [11:0] r1_m1;
    logic [11:0] c1_m1;
    logic        move_ok;
    logic [9:0]  tab_pos;
    logic [11:0] code;
    logic [11:0] fg_off;
    logic [11:0] bg_off;
    logic [5:0]  attr_base;

    // screen size clamped to 1..256
    always_comb
    begin
        if (width_cfg == 9'd0)
            w = 9'd1;
        else if (width_cfg > DIM_MAX)
            w = DIM_MAX;
        else
            w = width_cfg;
        if (height_cfg == 9'd0)
            h = 9'd1;
        else if (height_cfg > DIM_MAX)
            h = DIM_MAX;
        else
            h = height_cfg;
    end

    assign w_m1 = w - 9'd1;

    // shared operands
    always_comb
    begin
        n_down = cmd.first_present ? cmd.first_value : 12'd1;
        if (({1'b0, cur.row} + 9'd1) < h)
            avail = h - 9'd1 - {1'b0, cur.row};
        else
            avail = 9'd0;
        moved = (n_down < {3'b000, avail}) ? n_down[8:0] : avail;

        count = (cmd.first_present && (cmd.first_value != 12'd0)) ? cmd.first_value : 12'd1;
        right_sum = {5'd0, cur.col} + {1'b0, count};

        r1 = cmd.first_present  ? cmd.first_value  : 12'd1;
        c1 = cmd.second_present ? cmd.second_value : 12'd1;
        r1_m1 = r1 - 12'd1;
        c1_m1 = c1 - 12'd1;
        move_ok = (r1 != 12'd0) && (r1 <= {3'b000, h}) &&
                  (c1 != 12'd0) && (c1 <= {3'b000, w});

        tab_pos = (({2'b00, cur.col} / TAB_W) + 10'd1) * TAB_W;

        code = cmd.first_present ? cmd.first_value : SGR_RESET;
        fg_off = code - SGR_FG_FIRST;
        bg_off = code - SGR_BG_FIRST;
        attr_base = cmd.sgr_start ? 6'd0 : cur.attr;
    end

    // per-command update
    always_comb
    begin
        nxt = cur;
        status.scroll = 12'd0;
        status.rejected = 1'b0;
        case (cmd.mode)
            MODE_CR:
            begin
                nxt.col = 8'd0;
            end
            MODE_DOWN:
            begin
                status.scroll = n_down - {3'b000, moved};
                if (moved != 9'd0)
                begin
                    nxt.row = cur.row + moved[7:0];
                    nxt.col = 8'd0;
                end
            end
            MODE_UP:
            begin
                nxt.row = ({4'd0, cur.row} > count) ? (cur.row - count[7:0]) : 8'd0;
            end
            MODE_RIGHT:
            begin
                nxt.col = (right_sum >= {4'd0, w}) ? w_m1[7:0] : right_sum[7:0];
            end
            MODE_LEFT:
            begin
                nxt.col = ({4'd0, cur.col} > count) ? (cur.col - count[7:0]) : 8'd0;
            end
            MODE_MOVE:
            begin
                if (move_ok)
                begin
                    nxt.row = r1_m1[7:0];
                    nxt.col = c1_m1[7:0];
                end
                else
                begin
                    status.rejected = 1'b1;
                end
            end
            MODE_TAB:
            begin
                nxt.col = (tab_pos >= {1'b0, w}) ? w_m1[7:0] : tab_pos[7:0];
            end
            MODE_BACKSPACE:
            begin
                if (cur.col != 8'd0)
                    nxt.col = cur.col - 8'd1;
                else if (cur.row != 8'd0)
                    nxt.row = cur.row - 8'd1;
            end
            MODE_SGR:
            begin
                nxt.attr = attr_base;
                if (code == SGR_RESET)
                    nxt.attr = 6'd0;
                else if (code == SGR_BRIGHT)
                    nxt.attr[ATTR_BRIGHT] = 1'b1;
                else if (code == SGR_DIM)
                    nxt.attr[ATTR_DIM] = 1'b1;
                else if (code == SGR_UNDERSCORE)
                    nxt.attr[ATTR_UNDERSCORE] = 1'b1;
                else if (code == SGR_BLINK)
                    nxt.attr[ATTR_BLINK] = 1'b1;
                else if (code == SGR_REVERSE)
                    nxt.attr[ATTR_REVERSE] = 1'b1;
                else if (code == SGR_HIDDEN)
                    nxt.attr[ATTR_HIDDEN] = 1'b1;
                else if ((code >= SGR_FG_FIRST) && (code <= SGR_FG_LAST))
                    // 38 and 39 fall back to the default foreground
                    nxt.fg = (fg_off > 12'd7) ? FG_DEFAULT : fg_off[2:0];
                else if ((code >= SGR_BG_FIRST) && (code <= SGR_BG_LAST))
                    nxt.bg = (bg_off > 12'd7) ? BG_DEFAULT : bg_off[2:0];
                else
                    status.rejected = 1'b1;
            end
            default:
            begin
                // unused codes leave the state alone
                nxt = cur;
            end
        endcase
    end

endmodule : ctae_exec
`default_nettype wire

@@ sv/terminal_cursor_attribute_engine_core.sv @@
// top level of the terminal cursor and attribute engine
// a request is captured in the input register, and its result in the state register
// throughput: one request per cycle while the output is not stalled, set by the state update
// loop in the execute stage (cursor and rendition registers feed back into it)
// reset: cursor at 0,0, attributes clear, white on black, screen 80 by 24,
// both pipeline stages empty
`timescale 1ns / 1ps
`default_nettype none
module terminal_cursor_attribute_engine_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [8:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [3:0]  mode,
    input  wire logic [11:0] first_value,
    input  wire logic        first_present,
    input  wire logic [11:0] second_value,
    input  wire logic        second_present,
    input  wire logic        sgr_start,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       cursor_col,
    output logic [7:0]       cursor_row,
    output logic [5:0]       attr_bits,
    output logic [2:0]       fg_color,
    output logic [2:0]       bg_color,
    output logic [11:0]      scroll_lines,
    output logic             rejected
);
    import ctae_pkg::*;

    logic [8:0]  width_reg;
    logic [8:0]  height_reg;
    logic        s1_valid_reg;
    cmd_t        s1_cmd_reg;
    logic        out_valid_reg;
    term_state_t state_reg;
    status_t     status_reg;
    term_state_t state_next;
    status_t     status_next;
    logic        advance;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                REG_SCREEN_HEIGHT: height_reg <= cfg_data;
                default:           width_reg  <= width_reg;
            endcase
        end
    end

    // pipeline flow control
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!in_stall)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            s1_cmd_reg.mode           <= mode;
            s1_cmd_reg.first_value    <= first_value;
            s1_cmd_reg.first_present  <= first_present;
            s1_cmd_reg.second_value   <= second_value;
            s1_cmd_reg.second_present <= second_present;
            s1_cmd_reg.sgr_start      <= sgr_start;
        end
    end

    // execute stage
    ctae_exec u_exec (
        .cmd        (s1_cmd_reg),
        .cur        (state_reg),
        .width_cfg  (width_reg),
        .height_cfg (height_reg),
        .nxt        (state_next),
        .status     (status_next)
    );

    // state doubles as the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            state_reg.col  <= 8'd0;
            state_reg.row  <= 8'd0;
            state_reg.attr <= 6'd0;
            state_reg.fg   <= FG_DEFAULT;
            state_reg.bg   <= BG_DEFAULT;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            status_reg <= status_next;
    end

    // result ports
    assign out_valid    = out_valid_reg;
    assign cursor_col   = state_reg.col;
    assign cursor_row   = state_reg.row;
    assign attr_bits    = state_reg.attr;
    assign fg_color     = state_reg.fg;
    assign bg_color     = state_reg.bg;
    assign scroll_lines = status_reg.scroll;
    assign rejected     = status_reg.rejected;

    // checks
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with empty input stage");

    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced request did not reach the output");

    a_scroll_not_rejected: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg.scroll != 12'd0)) |-> !status_reg.rejected)
        else $error("scroll and reject reported together");

    a_state_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(state_reg.col) && $stable(state_reg.row) &&
                      $stable(state_reg.attr)))
        else $error("state changed without a request");

endmodule : terminal_cursor_attribute_engine_core
`default_nettype wire

@@ test/terminal_state_checker.sv @@
// checker for the cursor and attribute engine: tracks requests, predicts and compares responses
`timescale 1ns / 1ps
module terminal_state_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [8:0]  cfg_data,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [3:0]  mode,
    input  wire logic [11:0] first_value,
    input  wire logic        first_present,
    input  wire logic [11:0] second_value,
    input  wire logic        second_present,
    input  wire logic        sgr_start,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [7:0]  cursor_col,
    input  wire logic [7:0]  cursor_row,
    input  wire logic [5:0]  attr_bits,
    input  wire logic [2:0]  fg_color,
    input  wire logic [2:0]  bg_color,
    input  wire logic [11:0] scroll_lines,
    input  wire logic        rejected,
    output int               mismatch_count,
    output int               outstanding
);
    import ctae_pkg::*;

    typedef struct packed {
        term_state_t screen;
        status_t     status;
    } response_t;

    // responses still owed by the engine, oldest first
    response_t expected_screen_q[$];

    // predicted registers and terminal state
    logic [8:0] width_reg;
    logic [8:0] height_reg;
    int         col_now;
    int         row_now;
    logic [5:0] attr_now;
    logic [2:0] fg_now;
    logic [2:0] bg_now;

    cmd_t request;

    assign request = {mode, first_value, first_present, second_value, second_present, sgr_start};

    // out-of-range register values behave as the nearest legal size
    function automatic int dim_in_use(logic [8:0] value);
        if (value == '0)
            return 1;
        if (value > DIM_MAX)
            return int'(DIM_MAX);
        return int'(value);
    endfunction

    // a missing or zero count moves by one
    function automatic int step_count(cmd_t c);
        if (!c.first_present || c.first_value == '0)
            return 1;
        return int'(c.first_value);
    endfunction

    // one sgr parameter, returns 1 when the code is not recognised
    function automatic logic apply_sgr_code(logic [11:0] code);
        logic [11:0] offset;
        case (code)
            SGR_RESET:      attr_now = '0;
            SGR_BRIGHT:     attr_now[ATTR_BRIGHT] = 1'b1;
            SGR_DIM:        attr_now[ATTR_DIM] = 1'b1;
            SGR_UNDERSCORE: attr_now[ATTR_UNDERSCORE] = 1'b1;
            SGR_BLINK:      attr_now[ATTR_BLINK] = 1'b1;
            SGR_REVERSE:    attr_now[ATTR_REVERSE] = 1'b1;
            SGR_HIDDEN:     attr_now[ATTR_HIDDEN] = 1'b1;
            default:
            begin
                if (code >= SGR_FG_FIRST && code <= SGR_FG_LAST)
                begin
                    // 38 and 39 fall back to the default colour
                    offset = code - SGR_FG_FIRST;
                    fg_now = (offset > 12'd7) ? FG_DEFAULT : offset[2:0];
                end
                else if (code >= SGR_BG_FIRST && code <= SGR_BG_LAST)
                begin
                    offset = code - SGR_BG_FIRST;
                    bg_now = (offset > 12'd7) ? BG_DEFAULT : offset[2:0];
                end
                else
                    return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    // advance the predicted terminal by one command
    function automatic response_t apply_command(cmd_t c);
        int w;
        int h;
        int n;
        int avail;
        int moved;
        int t;
        int r1;
        int c1;
        response_t r;
        w = dim_in_use(width_reg);
        h = dim_in_use(height_reg);
        r.status = '0;
        case (c.mode)
            MODE_CR:
                col_now = 0;
            MODE_DOWN:
            begin
                // a present zero moves nothing; lines past the bottom scroll
                n = c.first_present ? int'(c.first_value) : 1;
                avail = (row_now + 1 < h) ? h - 1 - row_now : 0;
                moved = (n < avail) ? n : avail;
                r.status.scroll = 12'(n - moved);
                if (moved > 0)
                begin
                    row_now += moved;
                    col_now = 0;
                end
            end
            MODE_UP:
            begin
                n = step_count(c);
                row_now = (row_now > n) ? row_now - n : 0;
            end
            MODE_RIGHT:
            begin
                t = col_now + step_count(c);
                col_now = (t >= w) ? w - 1 : t;
            end
            MODE_LEFT:
            begin
                n = step_count(c);
                col_now = (col_now > n) ? col_now - n : 0;
            end
            MODE_MOVE:
            begin
                // 1-based position, rejected without moving when off screen
                r1 = c.first_present ? int'(c.first_value) : 1;
                c1 = c.second_present ? int'(c.second_value) : 1;
                if (r1 >= 1 && r1 <= h && c1 >= 1 && c1 <= w)
                begin
                    row_now = r1 - 1;
                    col_now = c1 - 1;
                end
                else
                    r.status.rejected = 1'b1;
            end
            MODE_TAB:
            begin
                t = (col_now / TAB_STOP + 1) * TAB_STOP;
                col_now = (t >= w) ? w - 1 : t;
            end
            MODE_BACKSPACE:
            begin
                // at the left edge step up a row instead
                if (col_now > 0)
                    col_now -= 1;
                else if (row_now > 0)
                    row_now -= 1;
            end
            MODE_SGR:
            begin
                if (c.sgr_start)
                    attr_now = '0;
                r.status.rejected = apply_sgr_code(c.first_present ? c.first_value : SGR_RESET);
            end
            default:
                ;
        endcase
        r.screen.col  = 8'(col_now);
        r.screen.row  = 8'(row_now);
        r.screen.attr = attr_now;
        r.screen.fg   = fg_now;
        r.screen.bg   = bg_now;
        return r;
    endfunction

    task automatic check_field(string name, int got, int want);
        if (got != want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin
        response_t want;
        if (!rst_n)
        begin
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            col_now    = 0;
            row_now    = 0;
            attr_now   = '0;
            fg_now     = FG_DEFAULT;
            bg_now     = BG_DEFAULT;
            expected_screen_q.delete();
            mismatch_count = 0;
            outstanding    = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_SCREEN_WIDTH)
                    width_reg = cfg_data;
                else
                    height_reg = cfg_data;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_screen_q.size() == 0)
                begin
                    $display("%0t: response with no request waiting, expected none, %s",
                             $time, $sformatf("got col %0d row %0d", cursor_col, cursor_row));
                    mismatch_count++;
                end
                else
                begin
                    want = expected_screen_q.pop_front();
                    check_field("cursor_col", cursor_col, want.screen.col);
                    check_field("cursor_row", cursor_row, want.screen.row);
                    check_field("attr_bits", attr_bits, want.screen.attr);
                    check_field("fg_color", fg_color, want.screen.fg);
                    check_field("bg_color", bg_color, want.screen.bg);
                    check_field("scroll_lines", scroll_lines, want.status.scroll);
                    check_field("rejected", rejected, want.status.rejected);
                end
            end
            if (in_valid && !in_stall)
                expected_screen_q.push_back(apply_command(request));
            outstanding = expected_screen_q.size();
        end
    end

endmodule

@@ test/testbench.sv @@
// top of the cursor and attribute engine testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module testbench;
    import ctae_pkg::*;

    localparam int PHASE_REQUESTS = 125;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int LONG_HOLD      = 80;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [8:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [3:0]  mode;
    logic [11:0] first_value;
    logic        first_present;
    logic [11:0] second_value;
    logic        second_present;
    logic        sgr_start;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  cursor_col;
    logic [7:0]  cursor_row;
    logic [5:0]  attr_bits;
    logic [2:0]  fg_color;
    logic [2:0]  bg_color;
    logic [11:0] scroll_lines;
    logic        rejected;

    int mismatch_count;
    int outstanding;
    int cycle_count   = 0;
    int hold_requests = 0;
    bit sender_pauses   = 1'b0;
    bit receiver_pauses = 1'b0;
    int cur_w = 80;
    int cur_h = 24;

    always #1 clk = ~clk;

    terminal_cursor_attribute_engine_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .first_value    (first_value),
        .first_present  (first_present),
        .second_value   (second_value),
        .second_present (second_present),
        .sgr_start      (sgr_start),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .cursor_col     (cursor_col),
        .cursor_row     (cursor_row),
        .attr_bits      (attr_bits),
        .fg_color       (fg_color),
        .bg_color       (bg_color),
        .scroll_lines   (scroll_lines),
        .rejected       (rejected)
    );

    terminal_state_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .first_value    (first_value),
        .first_present  (first_present),
        .second_value   (second_value),
        .second_present (second_present),
        .sgr_start      (sgr_start),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .cursor_col     (cursor_col),
        .cursor_row     (cursor_row),
        .attr_bits      (attr_bits),
        .fg_color       (fg_color),
        .bg_color       (bg_color),
        .scroll_lines   (scroll_lines),
        .rejected       (rejected),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    // response side: random stall bursts plus the occasional long hold-off
    initial
    begin
        int served;
        int burst;
        served = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (served != hold_requests)
            begin
                served = hold_requests;
                burst = LONG_HOLD;
            end
            else if (receiver_pauses && $urandom_range(0, 99) < 15)
                burst = $urandom_range(1, 10);
            else
                burst = 0;
            out_stall <= (burst != 0);
            if (burst > 1)
                repeat (burst - 1) @(negedge clk);
        end
    end

    function automatic cmd_t make_cmd(logic [3:0] m, int v1, bit p1, int v2, bit p2, bit s);
        return {m, 12'(v1), p1, 12'(v2), p2, s};
    endfunction

    // request side idle cycles, payload scrambled while not valid
    task automatic sender_gap(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            {mode, first_value, first_present, second_value, second_present, sgr_start}
                <= cmd_t'($urandom);
        end
    endtask

    task automatic send(cmd_t c);
        if (sender_pauses && $urandom_range(0, 99) < 20)
            sender_gap($urandom_range(1, 10));
        @(negedge clk);
        in_valid <= 1'b1;
        {mode, first_value, first_present, second_value, second_present, sgr_start} <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        sender_gap(1);
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic write_register(logic idx, logic [8:0] value);
        int used;
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        // keep the stimulus shaped to the size the engine will use
        used = (value == '0) ? 1 : (value > DIM_MAX) ? int'(DIM_MAX) : int'(value);
        if (idx == REG_SCREEN_WIDTH)
            cur_w = used;
        else
            cur_h = used;
    endtask

    task automatic set_screen(logic [8:0] w, logic [8:0] h);
        wait_drained();
        write_register(REG_SCREEN_WIDTH, w);
        write_register(REG_SCREEN_HEIGHT, h);
    endtask

    // counts biased towards small moves, with the extremes mixed in
    function automatic logic [11:0] random_count();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 12'hFFF;
            2, 3:    return 12'($urandom_range(0, 4095));
            4, 5:    return 12'($urandom_range(0, 300));
            default: return 12'($urandom_range(0, 12));
        endcase
    endfunction

    function automatic logic [11:0] random_sgr_code();
        case ($urandom_range(0, 9))
            0:       return 12'($urandom_range(0, 4095));
            1, 2:    return 12'($urandom_range(0, 60));
            3, 4, 5: return 12'($urandom_range(SGR_FG_FIRST, SGR_FG_LAST));
            6, 7:    return 12'($urandom_range(SGR_BG_FIRST, SGR_BG_LAST));
            default:
            begin
                case ($urandom_range(0, 6))
                    0:       return SGR_RESET;
                    1:       return SGR_BRIGHT;
                    2:       return SGR_DIM;
                    3:       return SGR_UNDERSCORE;
                    4:       return SGR_BLINK;
                    5:       return SGR_REVERSE;
                    default: return SGR_HIDDEN;
                endcase
            end
        endcase
    endfunction

    function automatic cmd_t random_command();
        cmd_t c;
        c = cmd_t'($urandom);
        c.first_present = ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 24) == 0)
            c.mode = 4'($urandom_range(MODE_SGR + 1, 15));
        else
            c.mode = 4'($urandom_range(MODE_CR, MODE_SGR));
        if (c.mode == MODE_MOVE && $urandom_range(0, 4) != 0)
        begin
            // mostly near the screen, a step past either edge included
            c.first_value    = 12'($urandom_range(0, cur_h + 1));
            c.second_value   = 12'($urandom_range(0, cur_w + 1));
            c.second_present = ($urandom_range(0, 9) != 0);
        end
        else if (c.mode != MODE_MOVE)
            c.first_value = random_count();
        return c;
    endfunction

    // one sgr sequence: start flag on the first parameter, now and then broken
    task automatic send_sgr_sequence(output int length);
        cmd_t c;
        length = $urandom_range(1, 4);
        for (int k = 0; k < length; k++)
        begin
            c = random_command();
            c.mode        = MODE_SGR;
            c.first_value = random_sgr_code();
            c.sgr_start   = (k == 0);
            if ($urandom_range(0, 9) == 0)
                c.sgr_start = ~c.sgr_start;
            send(c);
        end
    endtask

    task automatic run_phase(int count, bit quiet);
        int   sent;
        int   repick;
        int   length;
        cmd_t c;
        sent   = 0;
        repick = 0;
        while (sent < count)
        begin
            // new idling pattern every few dozen requests
            if (sent >= repick)
            begin
                sender_pauses   = !quiet && ($urandom_range(0, 2) != 0);
                receiver_pauses = !quiet && ($urandom_range(0, 2) != 0);
                repick = sent + 40;
            end
            c = random_command();
            if (c.mode == MODE_SGR)
            begin
                send_sgr_sequence(length);
                sent += length;
            end
            else
            begin
                send(c);
                sent++;
            end
        end
    endtask

    // edges and special cases on the reset-size screen
    task automatic run_directed();
        sender_pauses   = 1'b1;
        receiver_pauses = 1'b1;
        send(make_cmd(MODE_MOVE, 0, 0, 0, 0, 0));
        send(make_cmd(MODE_MOVE, 24, 1, 80, 1, 0));
        send(make_cmd(MODE_MOVE, 25, 1, 1, 1, 0));
        send(make_cmd(MODE_MOVE, 1, 1, 81, 1, 0));
        send(make_cmd(MODE_MOVE, 0, 1, 5, 1, 1));
        send(make_cmd(MODE_RIGHT, 4095, 1, 0, 0, 0));
        send(make_cmd(MODE_TAB, 0, 0, 4095, 1, 1));
        send(make_cmd(MODE_DOWN, 7, 0, 0, 0, 0));
        send(make_cmd(MODE_DOWN, 4095, 1, 0, 0, 0));
        send(make_cmd(MODE_UP, 0, 1, 0, 0, 0));
        send(make_cmd(MODE_UP, 4095, 1, 0, 0, 0));
        send(make_cmd(MODE_BACKSPACE, 0, 0, 0, 0, 0));
        send(make_cmd(MODE_LEFT, 4095, 1, 0, 0, 0));
        send(make_cmd(MODE_BACKSPACE, 4095, 1, 4095, 1, 1));
        send(make_cmd(MODE_DOWN, 0, 1, 0, 0, 0));
        send(make_cmd(MODE_DOWN, 3, 1, 0, 0, 0));
        send(make_cmd(MODE_BACKSPACE, 0, 0, 0, 0, 0));
        send(make_cmd(MODE_TAB, 0, 0, 0, 0, 0));
        send(make_cmd(MODE_CR, 4095, 1, 4095, 1, 1));
        send(make_cmd(MODE_SGR, SGR_BRIGHT, 1, 0, 0, 1));
        send(make_cmd(MODE_SGR, SGR_HIDDEN, 1, 0, 0, 0));
        send(make_cmd(MODE_SGR, SGR_FG_FIRST + 1, 1, 0, 0, 1));
        send(make_cmd(MODE_SGR, SGR_BG_FIRST + 7, 1, 0, 0, 0));
        send(make_cmd(MODE_SGR, SGR_FG_LAST, 1, 0, 0, 0));
        send(make_cmd(MODE_SGR, SGR_BG_LAST - 1, 1, 0, 0, 0));
        send(make_cmd(MODE_SGR, 3, 1, 0, 0, 1));
        send(make_cmd(MODE_SGR, 4095, 0, 0, 0, 0));
        send(make_cmd(4'd15, 4095, 1, 4095, 1, 1));
    endtask

    // main sequence
    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_SCREEN_WIDTH;
        cfg_data  = '0;
        in_valid  = 1'b0;
        {mode, first_value, first_present, second_value, second_present, sgr_start} = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        run_directed();

        // single-cell screen
        set_screen(1, 1);
        run_phase(PHASE_REQUESTS, 1'b0);

        // largest screen, then a long hold-off on the response side while requests keep coming
        set_screen(DIM_MAX, DIM_MAX);
        run_phase(60, 1'b0);
        hold_requests++;
        run_phase(60, 1'b1);
        send(make_cmd(MODE_MOVE, 250, 1, 250, 1, 0));

        // zero size, cursor left far outside the shrunk screen
        set_screen(0, 0);
        run_phase(PHASE_REQUESTS, 1'b0);

        // oversize values
        set_screen(9'd511, 9'd300);
        run_phase(PHASE_REQUESTS, 1'b0);

        // small screen with a full drain halfway
        set_screen(10, 5);
        run_phase(60, 1'b0);
        wait_drained();
        run_phase(60, 1'b0);

        set_screen(40, 12);
        run_phase(PHASE_REQUESTS, 1'b0);

        set_screen(9'($urandom_range(1, 256)), 9'($urandom_range(1, 256)));
        run_phase(PHASE_REQUESTS, 1'b0);

        // back to the reset size, flat out on both sides
        set_screen(WIDTH_RESET, HEIGHT_RESET);
        run_phase(PHASE_REQUESTS, 1'b1);

        wait_drained();
        repeat (8) @(negedge clk);
        if (mismatch_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

@@ files.f @@
sv/ctae_pkg.sv
sv/ctae_exec.sv
sv/terminal_cursor_attribute_engine_core.sv
test/terminal_state_checker.sv
test/testbench.sv
